// File: rtl/rtp_pkt_pkg.sv
// Shared types and constants for the RTP H.264 packetizer.
package rtp_pkt_pkg;

	localparam int MAX_PAYLOAD = 1400;
	localparam int CHUNK_MAX   = MAX_PAYLOAD - 2;
	localparam int RTP_HDR_LEN = 12;
	localparam int LEN_W       = $clog2(MAX_PAYLOAD + RTP_HDR_LEN + 1);
	localparam int POS_W       = $clog2(CHUNK_MAX);
	localparam int Q_DEPTH     = 4;
	localparam int Q_AW        = $clog2(Q_DEPTH);

	localparam logic [2:0] CFG_SSRC      = 3'd0;
	localparam logic [2:0] CFG_PT        = 3'd1;
	localparam logic [2:0] CFG_ILV_EN    = 3'd2;
	localparam logic [2:0] CFG_ILV_CHAN  = 3'd3;
	localparam logic [2:0] CFG_SEQ_START = 3'd4;
	localparam logic [2:0] CFG_TS_START  = 3'd5;
	localparam logic [2:0] CFG_STEP      = 3'd6;

	localparam logic [7:0] RTP_V2       = 8'h80;
	localparam logic [7:0] ILV_MAGIC    = 8'h24;
	localparam logic [7:0] NRI_MASK     = 8'he0;
	localparam logic [7:0] FU_A_TYPE    = 8'd28;
	localparam logic [7:0] FU_START_BIT = 8'h80;
	localparam logic [7:0] FU_END_BIT   = 8'h40;

	typedef struct packed {
		logic [7:0]  nal_data;
		logic        nal_first;
		logic        nal_last;
		logic [15:0] nal_bytes;
		logic        frame_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_data;
		logic       packet_done;
		logic       run_last;
	} out_item_t;

	// One queued command: optional header burst plus one payload byte
	typedef struct packed {
		logic             has_hdr;
		logic             has_fu;
		logic             marker;
		logic [15:0]      seq;
		logic [31:0]      ts;
		logic [LEN_W-1:0] total;
		logic [7:0]       fu_ind;
		logic [7:0]       fu_hdr;
		logic [7:0]       data;
		logic             done;
	} cmd_t;

	typedef struct packed {
		logic        seq_load;
		logic        ts_load;
		logic [31:0] wdata;
		logic [31:0] step;
	} front_cfg_t;

	typedef struct packed {
		logic [31:0] ssrc;
		logic [6:0]  pt;
		logic        ilv_en;
		logic [7:0]  ilv_chan;
	} hdr_cfg_t;

endpackage

// File: rtl/rtp_pkt_front.sv
// Front end: accepts NAL bytes, tracks NAL/fragment state, issues commands.
module rtp_pkt_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  rtp_pkt_pkg::in_item_t   in_item,
	input  rtp_pkt_pkg::front_cfg_t cfg,
	input  logic                    q_full,
	output logic                    q_push,
	output rtp_pkt_pkg::cmd_t       q_cmd
);

	logic [15:0] len_q;
	logic [15:0] off_q;
	logic [rtp_pkt_pkg::POS_W-1:0] pos_q;
	logic [7:0]  ind_q;
	logic [4:0]  utype_q;
	logic        frag_q;
	logic        mark_q;
	logic [15:0] seq_q;
	logic [31:0] ts_q;

	logic        accept;
	logic        first;
	logic [15:0] len_eff;
	logic [15:0] held;
	logic [15:0] o;
	logic        frag;
	logic        mark;
	logic        active;
	logic        hdr_byte;
	logic        hdr;
	logic [15:0] rem;
	logic        frag_end;
	logic [15:0] payload;
	logic        done;
	logic [15:0] off_next;
	logic        pos_wrap;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign first    = in_item.nal_first;
	assign len_eff  = (in_item.nal_bytes == 16'd0) ? 16'd1 : in_item.nal_bytes;
	assign held     = first ? len_eff : len_q;
	assign o        = first ? 16'd0 : off_q;
	assign frag     = first ? (len_eff > 16'(rtp_pkt_pkg::MAX_PAYLOAD)) : frag_q;
	assign mark     = first ? in_item.frame_last : mark_q;
	assign active   = first || (off_q < len_q);
	assign hdr_byte = frag && (o == 16'd0);
	assign rem      = held - o;
	assign frag_end = rem <= 16'(rtp_pkt_pkg::CHUNK_MAX);
	assign pos_wrap = pos_q == rtp_pkt_pkg::POS_W'(rtp_pkt_pkg::CHUNK_MAX - 1);
	assign off_next = o + 16'd1;

	always_comb begin
		if (frag) begin
			hdr     = (pos_q == '0);
			payload = (frag_end ? rem : 16'(rtp_pkt_pkg::CHUNK_MAX)) + 16'd2;
			done    = (off_next == held) || pos_wrap;
		end else begin
			hdr     = (o == 16'd0);
			payload = held;
			done    = (off_next == held);
		end
	end

	assign q_push = accept && active && !hdr_byte;

	always_comb begin
		q_cmd.has_hdr = hdr;
		q_cmd.has_fu  = frag;
		q_cmd.marker  = mark && (!frag || frag_end);
		q_cmd.seq     = seq_q;
		q_cmd.ts      = ts_q;
		q_cmd.total   = rtp_pkt_pkg::LEN_W'(payload + 16'(rtp_pkt_pkg::RTP_HDR_LEN));
		q_cmd.fu_ind  = ind_q;
		q_cmd.fu_hdr  = ((o == 16'd1) ? rtp_pkt_pkg::FU_START_BIT : 8'd0)
			| (frag_end ? rtp_pkt_pkg::FU_END_BIT : 8'd0) | {3'd0, utype_q};
		q_cmd.data    = in_item.nal_data;
		q_cmd.done    = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			off_q   <= '0;
			pos_q   <= '0;
			ind_q   <= '0;
			utype_q <= '0;
			frag_q  <= 1'b0;
			mark_q  <= 1'b0;
			seq_q   <= '0;
			ts_q    <= '0;
		end else begin
			if (cfg.seq_load) begin
				seq_q <= cfg.wdata[15:0];
			end
			if (cfg.ts_load) begin
				ts_q <= cfg.wdata;
			end
			if (accept && active) begin
				len_q  <= held;
				frag_q <= frag;
				mark_q <= mark;
				off_q  <= off_next;
				if (first) begin
					pos_q <= '0;
				end
				if (hdr_byte) begin
					ind_q   <= (in_item.nal_data & rtp_pkt_pkg::NRI_MASK) | rtp_pkt_pkg::FU_A_TYPE;
					utype_q <= in_item.nal_data[4:0];
				end else begin
					if (frag) begin
						pos_q <= pos_wrap ? '0 : pos_q + 1'b1;
					end
					if (hdr) begin
						seq_q <= seq_q + 16'd1;
					end
				end
				// advance timestamp after the last byte of an access unit
				if (off_next == held && mark) begin
					ts_q <= ts_q + cfg.step;
				end
			end
		end
	end

endmodule

// File: rtl/rtp_pkt_fifo.sv
// Short command queue between front end and byte sequencer.
module rtp_pkt_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rtp_pkt_pkg::cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output rtp_pkt_pkg::cmd_t head
);

	rtp_pkt_pkg::cmd_t mem_q [rtp_pkt_pkg::Q_DEPTH];
	logic [rtp_pkt_pkg::Q_AW-1:0] wr_ptr_q;
	logic [rtp_pkt_pkg::Q_AW-1:0] rd_ptr_q;
	logic [rtp_pkt_pkg::Q_AW:0]   count_q;

	assign full  = count_q == (rtp_pkt_pkg::Q_AW+1)'(rtp_pkt_pkg::Q_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/rtp_pkt_back.sv
// Back end: expands queued commands into prefix, RTP header, FU bytes and payload.
module rtp_pkt_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rtp_pkt_pkg::hdr_cfg_t  cfg,
	input  logic                   q_empty,
	input  rtp_pkt_pkg::cmd_t      q_head,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output rtp_pkt_pkg::out_item_t out_item
);

	localparam logic [4:0] P_ILV_MAGIC = 5'd0;
	localparam logic [4:0] P_ILV_CHAN  = 5'd1;
	localparam logic [4:0] P_ILV_LEN_H = 5'd2;
	localparam logic [4:0] P_ILV_LEN_L = 5'd3;
	localparam logic [4:0] P_VER       = 5'd4;
	localparam logic [4:0] P_PT        = 5'd5;
	localparam logic [4:0] P_SEQ_H     = 5'd6;
	localparam logic [4:0] P_SEQ_L     = 5'd7;
	localparam logic [4:0] P_TS_3      = 5'd8;
	localparam logic [4:0] P_TS_2      = 5'd9;
	localparam logic [4:0] P_TS_1      = 5'd10;
	localparam logic [4:0] P_TS_0      = 5'd11;
	localparam logic [4:0] P_SSRC_3    = 5'd12;
	localparam logic [4:0] P_SSRC_2    = 5'd13;
	localparam logic [4:0] P_SSRC_1    = 5'd14;
	localparam logic [4:0] P_SSRC_0    = 5'd15;
	localparam logic [4:0] P_FU_IND    = 5'd16;
	localparam logic [4:0] P_FU_HDR    = 5'd17;
	localparam logic [4:0] P_DATA      = 5'd18;

	logic       busy_q;
	logic [4:0] pos_q;
	logic       out_valid_q;
	rtp_pkt_pkg::out_item_t out_q;

	logic       adv;
	logic       emit;
	logic [4:0] start;
	logic [4:0] cur;
	logic [4:0] nxt;
	logic [7:0] byte_sel;

	assign adv   = !out_valid_q || out_ready;
	assign emit  = adv && !q_empty;
	assign start = !q_head.has_hdr ? P_DATA : (cfg.ilv_en ? P_ILV_MAGIC : P_VER);
	assign cur   = busy_q ? pos_q : start;
	assign nxt   = (cur == P_SSRC_0) ? (q_head.has_fu ? P_FU_IND : P_DATA) : cur + 5'd1;
	assign q_pop = emit && (cur == P_DATA);

	always_comb begin
		case (cur)
			P_ILV_MAGIC: byte_sel = rtp_pkt_pkg::ILV_MAGIC;
			P_ILV_CHAN:  byte_sel = cfg.ilv_chan;
			P_ILV_LEN_H: byte_sel = 8'(q_head.total >> 8);
			P_ILV_LEN_L: byte_sel = q_head.total[7:0];
			P_VER:       byte_sel = rtp_pkt_pkg::RTP_V2;
			P_PT:        byte_sel = {q_head.marker, cfg.pt};
			P_SEQ_H:     byte_sel = q_head.seq[15:8];
			P_SEQ_L:     byte_sel = q_head.seq[7:0];
			P_TS_3:      byte_sel = q_head.ts[31:24];
			P_TS_2:      byte_sel = q_head.ts[23:16];
			P_TS_1:      byte_sel = q_head.ts[15:8];
			P_TS_0:      byte_sel = q_head.ts[7:0];
			P_SSRC_3:    byte_sel = cfg.ssrc[31:24];
			P_SSRC_2:    byte_sel = cfg.ssrc[23:16];
			P_SSRC_1:    byte_sel = cfg.ssrc[15:8];
			P_SSRC_0:    byte_sel = cfg.ssrc[7:0];
			P_FU_IND:    byte_sel = q_head.fu_ind;
			P_FU_HDR:    byte_sel = q_head.fu_hdr;
			P_DATA:      byte_sel = q_head.data;
			default:     byte_sel = q_head.data;
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_data    <= byte_sel;
			out_q.packet_done <= (cur == P_DATA) && q_head.done;
			out_q.run_last    <= (cur == P_DATA);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
			if (emit) begin
				// hold position until the payload byte retires the command
				busy_q <= (cur != P_DATA);
				pos_q  <= nxt;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// File: rtl/rtp_h264_packetizer_unit.sv
// Path: an accepted input beat is written to the command queue, and the byte
// sequencer registers the output beat. Throughput: one output beat per cycle
// while out_ready allows; a packet start puts header bytes before its payload.
// The four-entry command queue lets input run ahead during header bursts.
// Reset: all control state cleared, registers take their documented defaults.
module rtp_h264_packetizer_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  rtp_pkt_pkg::in_item_t  in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output rtp_pkt_pkg::out_item_t out_item,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [31:0]            cfg_wdata
);

	logic [31:0] ssrc_q;
	logic [6:0]  pt_q;
	logic        ilv_en_q;
	logic [7:0]  ilv_chan_q;
	logic [31:0] step_q;

	rtp_pkt_pkg::front_cfg_t front_cfg;
	rtp_pkt_pkg::hdr_cfg_t   hdr_cfg;
	rtp_pkt_pkg::cmd_t       push_cmd;
	rtp_pkt_pkg::cmd_t       head_cmd;
	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ssrc_q     <= '0;
			pt_q       <= 7'd96;
			ilv_en_q   <= 1'b0;
			ilv_chan_q <= '0;
			step_q     <= 32'd3600;
		end else if (cfg_we) begin
			case (cfg_index)
				rtp_pkt_pkg::CFG_SSRC:     ssrc_q     <= cfg_wdata;
				rtp_pkt_pkg::CFG_PT:       pt_q       <= cfg_wdata[6:0];
				rtp_pkt_pkg::CFG_ILV_EN:   ilv_en_q   <= cfg_wdata[0];
				rtp_pkt_pkg::CFG_ILV_CHAN: ilv_chan_q <= cfg_wdata[7:0];
				rtp_pkt_pkg::CFG_STEP:     step_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		front_cfg.seq_load = cfg_we && (cfg_index == rtp_pkt_pkg::CFG_SEQ_START);
		front_cfg.ts_load  = cfg_we && (cfg_index == rtp_pkt_pkg::CFG_TS_START);
		front_cfg.wdata    = cfg_wdata;
		front_cfg.step     = step_q;
		hdr_cfg.ssrc       = ssrc_q;
		hdr_cfg.pt         = pt_q;
		hdr_cfg.ilv_en     = ilv_en_q;
		hdr_cfg.ilv_chan   = ilv_chan_q;
	end

	rtp_pkt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.cfg      (front_cfg),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	rtp_pkt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (head_cmd)
	);

	rtp_pkt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (hdr_cfg),
		.q_empty   (q_empty),
		.q_head    (head_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
